>>> rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted minimum priority queue package
// Shared constants, codes and the structs broadcast to and passed along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int CAPACITY  = 64;
  localparam int KEY_BITS  = 32;
  localparam int OCC_BITS  = 7;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef logic signed [KEY_BITS-1:0] key_t;
  typedef logic [OCC_BITS-1:0]        count_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic ins;
    logic del;
    key_t key;
  } cmd_t;

  // What a cell hands to its right-hand neighbour.
  typedef struct packed {
    logic hit;
    key_t key;
  } link_t;

endpackage

`default_nettype wire

>>> rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// Sorted minimum priority queue cell
// Holds one key; on insertion it keeps its key, takes the new key or takes
// its left neighbour's key, and on removal it takes its right neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_cell (
  input  wire logic           clk,
  input  wire smpq_pkg::cmd_t cmd_i,
  input  wire logic           occ_i,
  input  wire smpq_pkg::link_t left_i,
  input  wire smpq_pkg::key_t right_key_i,
  output      smpq_pkg::link_t link_o
);
  import smpq_pkg::*;

  key_t key_r;
  key_t key_nxt;
  logic hit;

  // The cell lies at or beyond the insertion point when it is empty or its
  // key is strictly greater than the new one, so equal keys stay in order.
  assign hit = !occ_i || (key_r > cmd_i.key);

  always_comb begin
    key_nxt = key_r;
    if (cmd_i.ins && hit) begin
      key_nxt = left_i.hit ? left_i.key : cmd_i.key;
    end else if (cmd_i.del) begin
      key_nxt = right_key_i;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link_o.hit = hit;
  assign link_o.key = key_r;

endmodule

`default_nettype wire

>>> rtl/sorted_min_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted minimum priority queue
// A row of cells keeps the keys in ascending order; every request inserts a
// key or removes the smallest one, unless the queue is full or empty, and reports status and occupancy.
//
// Channel  | Direction | Ports                                   | Handshake
// request  | in        | in_kind, in_key_in                      | in_valid/in_ready
// response | out       | out_key_out, out_status, out_occupancy  | out_valid/out_ready
//
// Each request is applied to all cells at once in the cycle it is taken, so
// one request is accepted per cycle if not stalled; its response follows next cycle.
// The comparison in every cell against the broadcast key sets the cycle time.
// Reset empties the queue and clears the response valid flag.
// A response that is not taken holds the request channel until out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_min_priority_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  in_kind,
  input  wire smpq_pkg::key_t        in_key_in,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      smpq_pkg::key_t        out_key_out,
  output      logic [1:0]            out_status,
  output      smpq_pkg::count_t      out_occupancy
);
  import smpq_pkg::*;

  count_t  count_r;
  count_t  count_nxt;
  logic    out_valid_r;
  key_t    out_key_r;
  status_t out_status_r;
  count_t  out_occ_r;

  logic    accept;
  logic    full;
  logic    empty;
  cmd_t    cmd;
  key_t    key_res;
  status_t status_res;

  logic  occ [CAPACITY];
  link_t lnk [CAPACITY+1];

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == count_t'(CAPACITY));
  assign empty    = (count_r == '0);

  assign cmd.ins = accept && (in_kind == KIND_ENQ) && !full;
  assign cmd.del = accept && (in_kind == KIND_DEQ) && !empty;
  assign cmd.key = in_key_in;

  assign lnk[0] = '{hit: 1'b0, key: '0};

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = (count_r > count_t'(gi));
      if (gi < CAPACITY - 1) begin : g_mid
        smpq_cell u_cell (
          .clk         (clk),
          .cmd_i       (cmd),
          .occ_i       (occ[gi]),
          .left_i      (lnk[gi]),
          .right_key_i (lnk[gi+2].key),
          .link_o      (lnk[gi+1])
        );
      end else begin : g_last
        smpq_cell u_cell (
          .clk         (clk),
          .cmd_i       (cmd),
          .occ_i       (occ[gi]),
          .left_i      (lnk[gi]),
          .right_key_i (lnk[gi+1].key),
          .link_o      (lnk[gi+1])
        );
      end
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    key_res    = '0;
    status_res = ST_DONE;
    if (in_kind == KIND_ENQ) begin
      if (full) begin
        status_res = ST_FULL;
      end else begin
        count_nxt = count_r + count_t'(1);
      end
    end else begin
      if (empty) begin
        status_res = ST_EMPTY;
      end else begin
        key_res   = lnk[1].key;
        count_nxt = count_r - count_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key_r    <= key_res;
      out_status_r <= status_res;
      out_occ_r    <= count_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key_out   = out_key_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("Queue holds more keys than its capacity.");

  a_insert_occ : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (out_status == ST_DONE) && (out_occupancy == $past(count_r) + count_t'(1)))
    else $error("Insertion did not raise the occupancy by one.");

  a_remove_min : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del |=> (out_key_out == $past(lnk[1].key)) && (count_r == $past(count_r) - count_t'(1)))
    else $error("Removal did not return the head cell's key.");

  a_sorted_head : assert property (@(posedge clk) disable iff (!rst_n)
    (count_r > count_t'(1)) |-> (lnk[1].key <= lnk[2].key))
    else $error("The two smallest keys are out of order.");

endmodule

`default_nettype wire
